// ===== hdl/srkms_pkg.sv =====
// Shared constants for the key matrix scanner: field widths, phase codes and register map.
package srkms_pkg;

	localparam int FIELD_W    = 21;
	localparam int ROWNUM_W   = 3;
	localparam int PHASE_W    = 3;
	localparam int CNT_W      = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int STEP_MAX   = 6;

	localparam logic [PHASE_W-1:0] PH_DRIVE  = 3'd0;
	localparam logic [PHASE_W-1:0] PH_LOAD   = 3'd1;
	localparam logic [PHASE_W-1:0] PH_GAP    = 3'd2;
	localparam logic [PHASE_W-1:0] PH_SAMPLE = 3'd3;
	localparam logic [PHASE_W-1:0] PH_HIGH   = 3'd4;
	localparam logic [PHASE_W-1:0] PH_LOW    = 3'd5;
	localparam logic [PHASE_W-1:0] PH_IDLE   = 3'd6;

	localparam logic [CFG_IDX_W-1:0] REG_SETTLE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LATCH  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAP    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HALF   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 3'd4;

	localparam logic [15:0] SETTLE_RST = 16'd100;
	localparam logic [7:0]  LATCH_RST  = 8'd5;
	localparam logic [7:0]  GAP_RST    = 8'd1;
	localparam logic [7:0]  HALF_RST   = 8'd1;

endpackage

// ===== hdl/shift_register_key_matrix_scanner.sv =====
// Key matrix scanner top level: pin sequencing per tick, scan store and row report output.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_ready, serial_level          | tick in
//  out     | out_valid, out_ready, pins and row fields | result out
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | register write
//
// One tick is taken per cycle while the result register is free; it is worked out in the
// cycle it enters and lands in the result register. A tick that finishes a scan holds
// it for ROW_COUNT row items; a one-entry skid on the input keeps in_ready registered.
// Reset clears all control and key state; the scan restarts at column 0.
// A stall on out holds the result register; input then fills the skid and stops.
module shift_register_key_matrix_scanner
	import srkms_pkg::*;
#(
	parameter int ROW_COUNT    = 6,
	parameter int COLUMN_COUNT = 21
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  serial_level,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [FIELD_W-1:0]    column_drive,
	output logic                  load_n,
	output logic                  shift_clock,
	output logic                  row_report,
	output logic [ROWNUM_W-1:0]   row_number,
	output logic [FIELD_W-1:0]    row_keys,
	output logic                  matrix_changed,
	output logic                  last_row,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int CW = $clog2(COLUMN_COUNT + 1);
	localparam int BW = $clog2(ROW_COUNT + 1);
	localparam int RW = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;

	typedef logic [FIELD_W-1:0] row_t;

	// Configuration registers
	logic [15:0] settle_q;
	logic [7:0]  latch_q;
	logic [7:0]  gap_q;
	logic [7:0]  half_q;
	logic        enable_q;

	// Sequencer state
	logic [PHASE_W-1:0] phase_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CW-1:0]      col_q;
	logic [BW-1:0]      bit_q;
	row_t               scan_q   [ROW_COUNT];
	row_t               stored_q [ROW_COUNT];

	// Input skid
	logic skid_valid_q;
	logic skid_level_q;

	// Result register
	logic          res_valid_q;
	row_t          res_drive_q;
	logic          res_load_n_q;
	logic          res_clk_q;
	logic          res_fin_q;
	logic          res_changed_q;
	logic [RW-1:0] beat_q;

	// Step logic
	logic [PHASE_W-1:0] ph;
	logic [CNT_W-1:0]   cnt;
	logic [CW-1:0]      col;
	logic [BW-1:0]      bi;
	logic               fin;
	logic               clr;
	logic               changed;
	row_t               drive;
	logic               pin_load_n;
	logic               pin_clk;
	logic               level;
	logic               sample_hit;

	logic in_fire;
	logic out_fire;
	logic last_beat;
	logic res_free;
	logic take;

	function automatic logic [CNT_W-1:0] phase_len(input logic [PHASE_W-1:0] p,
		input logic [15:0] settle, input logic [7:0] latch, input logic [7:0] gap,
		input logic [7:0] half);
		case (p)
			PH_DRIVE: phase_len = settle;
			PH_LOAD:  phase_len = CNT_W'(latch);
			PH_GAP:   phase_len = CNT_W'(gap);
			PH_HIGH:  phase_len = CNT_W'(half);
			PH_LOW:   phase_len = CNT_W'(half);
			default:  phase_len = CNT_W'(1);
		endcase
	endfunction

	assign cfg_ready = 1'b1;
	assign in_ready  = !skid_valid_q;
	assign in_fire   = in_valid && in_ready;
	assign out_fire  = res_valid_q && out_ready;
	assign last_beat = !res_fin_q || (beat_q == RW'(ROW_COUNT - 1));
	assign res_free  = !res_valid_q || (out_ready && last_beat);
	assign take      = res_free && (skid_valid_q || in_fire);
	assign level     = skid_valid_q ? skid_level_q : serial_level;

	// Phase walk for one tick. Zero-length phases fall through; the sample phase always
	// stops the walk, so six passes cover the longest chain.
	always_comb begin
		ph  = phase_q;
		cnt = cnt_q;
		col = col_q;
		bi  = bit_q;
		fin = 1'b0;
		clr = 1'b0;
		if (ph == PH_IDLE) begin
			ph  = PH_DRIVE;
			cnt = '0;
			col = '0;
			bi  = '0;
			clr = 1'b1;
		end
		for (int i = 0; i < STEP_MAX; i++) begin
			if (cnt >= phase_len(ph, settle_q, latch_q, gap_q, half_q)) begin
				cnt = '0;
				unique case (ph)
					PH_DRIVE:  ph = PH_LOAD;
					PH_LOAD:   ph = PH_GAP;
					PH_GAP:    ph = PH_SAMPLE;
					PH_SAMPLE: ph = PH_HIGH;
					PH_HIGH:   ph = PH_LOW;
					PH_LOW: begin
						if (bi < BW'(ROW_COUNT - 1)) begin
							bi = bi + BW'(1);
							ph = PH_SAMPLE;
						end else begin
							bi = '0;
							ph = PH_DRIVE;
							if (col < CW'(COLUMN_COUNT - 1)) begin
								col = col + CW'(1);
							end else begin
								col = '0;
								fin = 1'b1;
								clr = 1'b1;
							end
						end
					end
					default: ph = PH_DRIVE;
				endcase
			end
		end
	end

	always_comb begin
		changed = 1'b0;
		for (int k = 0; k < ROW_COUNT; k++) begin
			if (scan_q[k] != stored_q[k]) begin
				changed = 1'b1;
			end
		end
		changed = changed && fin;
	end

	assign drive      = row_t'(1) << col;
	assign pin_load_n = (ph != PH_LOAD);
	assign pin_clk    = (ph == PH_HIGH);
	assign sample_hit = (ph == PH_SAMPLE) && level;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= SETTLE_RST;
			latch_q  <= LATCH_RST;
			gap_q    <= GAP_RST;
			half_q   <= HALF_RST;
			enable_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SETTLE: settle_q <= cfg_data;
				REG_LATCH:  latch_q  <= cfg_data[7:0];
				REG_GAP:    gap_q    <= cfg_data[7:0];
				REG_HALF:   half_q   <= cfg_data[7:0];
				REG_ENABLE: enable_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_valid_q <= 1'b0;
			skid_level_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				if (take) begin
					skid_valid_q <= 1'b0;
				end
			end else if (in_fire && !res_free) begin
				skid_valid_q <= 1'b1;
				skid_level_q <= serial_level;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_DRIVE;
			cnt_q   <= '0;
			col_q   <= '0;
			bit_q   <= '0;
			for (int k = 0; k < ROW_COUNT; k++) begin
				scan_q[k]   <= '0;
				stored_q[k] <= '0;
			end
		end else if (take) begin
			if (!enable_q) begin
				// Disabled: drop the partial scan and park.
				phase_q <= PH_IDLE;
				cnt_q   <= '0;
			end else begin
				phase_q <= ph;
				cnt_q   <= cnt + CNT_W'(1);
				col_q   <= col;
				bit_q   <= bi;
				for (int k = 0; k < ROW_COUNT; k++) begin
					if (sample_hit && (bi == BW'(k))) begin
						scan_q[k] <= (clr ? row_t'(0) : scan_q[k]) | drive;
					end else if (clr) begin
						scan_q[k] <= '0;
					end
					if (fin) begin
						stored_q[k] <= scan_q[k];
					end
				end
			end
		end
	end

	// The row items of a finished scan read the stored matrix, which cannot change again
	// until the result register has drained.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			beat_q      <= '0;
		end else if (take) begin
			res_valid_q <= 1'b1;
			beat_q      <= '0;
		end else if (out_fire) begin
			if (last_beat) begin
				res_valid_q <= 1'b0;
			end else begin
				beat_q <= beat_q + RW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_drive_q   <= enable_q ? drive : '0;
			res_load_n_q  <= enable_q ? pin_load_n : 1'b1;
			res_clk_q     <= enable_q && pin_clk;
			res_fin_q     <= enable_q && fin;
			res_changed_q <= enable_q && changed;
		end
	end

	assign out_valid      = res_valid_q;
	assign column_drive   = res_drive_q;
	assign load_n         = res_load_n_q;
	assign shift_clock    = res_clk_q;
	assign row_report     = res_fin_q;
	assign row_number     = res_fin_q ? ROWNUM_W'(beat_q) : '0;
	assign row_keys       = res_fin_q ? stored_q[beat_q] : '0;
	assign matrix_changed = res_fin_q && res_changed_q;
	assign last_row       = res_fin_q && (beat_q == RW'(ROW_COUNT - 1));

endmodule
